// ===== src/spq_pkg.sv =====
// Shared constants, codes and control types for the stable priority queue.
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int PRI_W = 16;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PEEK = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;   // capture the incoming word
		logic exec;   // apply the captured command and load the result
	} ctl_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Controller: sequences capture and execution, owns the output valid flag.
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output spq_pkg::ctl_t ctl
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ctl.load  = in_valid && (state_q == S_IDLE);
	// execute only once the result register is free or being drained
	assign ctl.exec  = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (!out_valid_q || out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/spq_dp.sv =====
// Datapath: sorted shift-register entry array, input capture and result register.
module spq_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spq_pkg::ctl_t              ctl,
	input  logic [1:0]                 command,
	input  logic signed [31:0]         value_in,
	input  logic signed [15:0]         priority_in,
	output logic signed [31:0]         value_out,
	output logic [1:0]                 status,
	output logic [spq_pkg::CNT_W-1:0]  occupancy
);

	localparam int N = spq_pkg::DEPTH;
	localparam int CW = spq_pkg::CNT_W;

	// captured word
	logic [1:0]                       cmd_q;
	logic signed [spq_pkg::VAL_W-1:0] val_in_q;
	logic signed [spq_pkg::PRI_W-1:0] pri_in_q;

	// entry cells, head at index 0
	logic signed [spq_pkg::VAL_W-1:0] val_q [N];
	logic signed [spq_pkg::PRI_W-1:0] pri_q [N];
	logic [CW-1:0]                    count_q;

	// result register
	logic signed [spq_pkg::VAL_W-1:0] res_val_q;
	logic [1:0]                       res_st_q;
	logic [CW-1:0]                    res_occ_q;

	logic [N-1:0] after;       // cell lies behind the insert point
	logic         is_full;
	logic         is_empty;
	logic         do_push;
	logic         do_pop;

	logic signed [spq_pkg::VAL_W-1:0] nxt_val;
	logic [1:0]                       nxt_st;
	logic [CW-1:0]                    nxt_cnt;

	assign is_full  = (count_q == CW'(N));
	assign is_empty = (count_q == '0);

	// empty cells count as "after", so the flags stay monotonic
	always_comb begin
		for (int i = 0; i < N; i++) begin
			after[i] = !(CW'(i) < count_q) || (pri_q[i] > pri_in_q);
		end
	end

	always_comb begin
		nxt_val = '0;
		nxt_st  = spq_pkg::ST_OK;
		nxt_cnt = count_q;
		do_push = 1'b0;
		do_pop  = 1'b0;
		case (spq_pkg::cmd_t'(cmd_q))
			spq_pkg::CMD_PUSH: begin
				if (is_full) begin
					nxt_st = spq_pkg::ST_FULL;
				end else begin
					do_push = 1'b1;
					nxt_cnt = count_q + CW'(1);
				end
			end
			spq_pkg::CMD_POP: begin
				if (is_empty) begin
					nxt_st = spq_pkg::ST_EMPTY;
				end else begin
					do_pop  = 1'b1;
					nxt_val = val_q[0];
					nxt_cnt = count_q - CW'(1);
				end
			end
			spq_pkg::CMD_PEEK: begin
				if (is_empty) begin
					nxt_st = spq_pkg::ST_EMPTY;
				end else begin
					nxt_val = val_q[0];
				end
			end
			default: begin
				nxt_st = spq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= command;
			val_in_q <= value_in;
			pri_in_q <= priority_in;
		end
	end

	// each cell keeps, takes the new entry, or shifts from a neighbor
	for (genvar i = 0; i < N; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctl.exec && do_push) begin
				if (i > 0 && after[(i > 0) ? i - 1 : 0]) begin
					val_q[i] <= val_q[(i > 0) ? i - 1 : 0];
					pri_q[i] <= pri_q[(i > 0) ? i - 1 : 0];
				end else if (after[i]) begin
					val_q[i] <= val_in_q;
					pri_q[i] <= pri_in_q;
				end
			end else if (ctl.exec && do_pop && i < N - 1) begin
				val_q[i] <= val_q[(i < N - 1) ? i + 1 : i];
				pri_q[i] <= pri_q[(i < N - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.exec) begin
			count_q <= nxt_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			res_val_q <= nxt_val;
			res_st_q  <= nxt_st;
			res_occ_q <= nxt_cnt;
		end
	end

	assign value_out = res_val_q;
	assign status    = res_st_q;
	assign occupancy = res_occ_q;

endmodule

// ===== src/stable_priority_queue_core.sv =====
// An accepted word is captured, then executed into the result register, raising result valid.
// No word is taken until the last executes; the controller's capture/execute sequence sets this,
// and a stalled result register holds execution until the word is taken.
// The insert point is found by comparing all 16 cells at once; push and pop shift all cells together.
// Reset (arst_n low, async): queue empty, no result pending, ready to accept.
// Entry storage holds no reset value; only entries below the count are ever read.
module stable_priority_queue_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic signed [31:0]        value_in,
	input  logic signed [15:0]        priority_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        value_out,
	output logic [1:0]                status,
	output logic [spq_pkg::CNT_W-1:0] occupancy
);

	// capture/execute strobes from the controller to the datapath
	spq_pkg::ctl_t ctl;

	// controller: two-state sequencer plus the output valid flag
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// datapath: sorted cell array, count, captured word and result register
	spq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.command     (command),
		.value_in    (value_in),
		.priority_in (priority_in),
		.value_out   (value_out),
		.status      (status),
		.occupancy   (occupancy)
	);

`ifndef SYNTHESIS
	// one word in flight: no new word right after a capture
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("word accepted while previous word executing");

	// a dropped push only happens at full occupancy
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::ST_FULL) |->
		(occupancy == spq_pkg::CNT_W'(spq_pkg::DEPTH)))
		else $error("full status with occupancy below depth");

	// empty report carries zero data and zero occupancy
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::ST_EMPTY) |-> (occupancy == '0 && value_out == '0))
		else $error("empty status with nonzero data or occupancy");

	// occupancy never exceeds the cell count
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= spq_pkg::CNT_W'(spq_pkg::DEPTH)))
		else $error("occupancy beyond depth");
`endif

endmodule
